>>> design/smev_pkg.sv
// Shared types and constants for the stack machine evaluator.
// No dependencies; used by every module of the block.
`default_nettype none

package smev_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int VALUE_BITS  = 20;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ANS_W       = VALUE_BITS + 1;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_DUP  = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4
  } op_t;

  // What the whole stack does in one step.
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_PUSH,
    SH_POP,
    SH_MERGE
  } stack_shift_t;

  // What a single cell does in one step.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_DOWN,
    CELL_UP
  } cell_mode_t;

  typedef struct packed {
    logic [2:0]            req_type;
    logic [VALUE_BITS-1:0] push_value;
    logic                  end_of_program;
  } in_item_t;

  typedef struct packed {
    logic signed [ANS_W-1:0] answer;
    logic                    program_done;
    logic                    error_seen;
  } out_item_t;

  typedef struct packed {
    stack_shift_t          shift;
    logic                  err_nxt;
    logic [CNT_W-1:0]      cnt_nxt;
    logic [VALUE_BITS-1:0] new_top;
  } alu_res_t;

endpackage

`default_nettype wire

>>> design/smev_cell.sv
// One stack entry: holds a value and takes it from either neighbor.
// Depends on smev_pkg.
`default_nettype none

module smev_cell (
  input  wire logic                            clk,
  input  wire smev_pkg::cell_mode_t            mode,
  input  wire logic [smev_pkg::VALUE_BITS-1:0] up_val,
  input  wire logic [smev_pkg::VALUE_BITS-1:0] down_val,
  output logic [smev_pkg::VALUE_BITS-1:0]      val
);

  logic [smev_pkg::VALUE_BITS-1:0] val_r;
  logic [smev_pkg::VALUE_BITS-1:0] val_nxt;

  always_comb begin
    case (mode)
      smev_pkg::CELL_DOWN: val_nxt = up_val;
      smev_pkg::CELL_UP:   val_nxt = down_val;
      default:             val_nxt = val_r;
    endcase
  end

  // entries never written are never read, so no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

>>> design/smev_alu.sv
// Decodes one operation against the two top cells, count and error flag.
// Depends on smev_pkg.
`default_nettype none

module smev_alu (
  input  wire logic [2:0]                      req_type,
  input  wire logic [smev_pkg::VALUE_BITS-1:0] push_value,
  input  wire logic [smev_pkg::VALUE_BITS-1:0] top,
  input  wire logic [smev_pkg::VALUE_BITS-1:0] next,
  input  wire logic [smev_pkg::CNT_W-1:0]      cnt,
  input  wire logic                            err,
  output smev_pkg::alu_res_t                   res
);

  logic [smev_pkg::VALUE_BITS:0]   sum;
  logic [smev_pkg::VALUE_BITS-1:0] diff;
  logic                            empty;
  logic                            full;
  logic                            short;

  assign sum   = {1'b0, top} + {1'b0, next};
  assign diff  = top - next;
  assign empty = (cnt == '0);
  assign full  = (cnt >= smev_pkg::CNT_W'(smev_pkg::STACK_DEPTH));
  assign short = (cnt < smev_pkg::CNT_W'(2));

  always_comb begin
    res.shift   = smev_pkg::SH_HOLD;
    res.err_nxt = err;
    res.cnt_nxt = cnt;
    res.new_top = top;
    if (!err) begin
      case (smev_pkg::op_t'(req_type))
        smev_pkg::OP_PUSH: begin
          if (full) begin
            res.err_nxt = 1'b1;
          end else begin
            res.shift   = smev_pkg::SH_PUSH;
            res.cnt_nxt = cnt + 1'b1;
            res.new_top = push_value;
          end
        end
        smev_pkg::OP_POP: begin
          if (empty) begin
            res.err_nxt = 1'b1;
          end else begin
            res.shift   = smev_pkg::SH_POP;
            res.cnt_nxt = cnt - 1'b1;
            res.new_top = next;
          end
        end
        smev_pkg::OP_DUP: begin
          if (empty || full) begin
            res.err_nxt = 1'b1;
          end else begin
            res.shift   = smev_pkg::SH_PUSH;
            res.cnt_nxt = cnt + 1'b1;
          end
        end
        smev_pkg::OP_ADD: begin
          if (short || sum[smev_pkg::VALUE_BITS]) begin
            res.err_nxt = 1'b1;
          end else begin
            res.shift   = smev_pkg::SH_MERGE;
            res.cnt_nxt = cnt - 1'b1;
            res.new_top = sum[smev_pkg::VALUE_BITS-1:0];
          end
        end
        smev_pkg::OP_SUB: begin
          if (short || (top < next)) begin
            res.err_nxt = 1'b1;
          end else begin
            res.shift   = smev_pkg::SH_MERGE;
            res.cnt_nxt = cnt - 1'b1;
            res.new_top = diff;
          end
        end
        default: res.err_nxt = 1'b1;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/stack_machine_evaluator_core.sv
// Stack machine evaluator: one operation per transfer, one result per operation,
// registered in the cycle after the transfer. The stack is a row of cells, top in cell 0,
// and every operation shifts every cell of the row together, so a new operation is taken
// every clock while the result register is free or being drained. No clearing pass.
// Depends on smev_pkg, smev_alu, smev_cell.
`default_nettype none

module stack_machine_evaluator_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire smev_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output smev_pkg::out_item_t      out_data
);

  localparam int DEPTH = smev_pkg::STACK_DEPTH;

  logic [smev_pkg::VALUE_BITS-1:0] cell_val [DEPTH];
  smev_pkg::cell_mode_t            cell_mode [DEPTH];

  logic [smev_pkg::CNT_W-1:0] cnt_r;
  logic                       err_r;
  logic                       out_valid_r;
  smev_pkg::out_item_t        out_r;
  smev_pkg::out_item_t        out_nxt;
  smev_pkg::alu_res_t         res;
  logic                       acc;

  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  smev_alu u_alu (
    .req_type   (in_data.req_type),
    .push_value (in_data.push_value),
    .top        (cell_val[0]),
    .next       (cell_val[1]),
    .cnt        (cnt_r),
    .err        (err_r),
    .res        (res)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [smev_pkg::VALUE_BITS-1:0] up_val;
    logic [smev_pkg::VALUE_BITS-1:0] down_val;

    if (i == 0) begin : g_head
      assign up_val = res.new_top;
    end else begin : g_body
      assign up_val = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign down_val = cell_val[i];
    end else begin : g_inner
      assign down_val = cell_val[i+1];
    end

    always_comb begin
      cell_mode[i] = smev_pkg::CELL_HOLD;
      if (acc) begin
        case (res.shift)
          smev_pkg::SH_PUSH:  cell_mode[i] = smev_pkg::CELL_DOWN;
          smev_pkg::SH_POP:   cell_mode[i] = smev_pkg::CELL_UP;
          // result lands in the head, the rest moves up one
          smev_pkg::SH_MERGE: cell_mode[i] = (i == 0) ? smev_pkg::CELL_DOWN
                                                      : smev_pkg::CELL_UP;
          default:            cell_mode[i] = smev_pkg::CELL_HOLD;
        endcase
      end
    end

    smev_cell u_cell (
      .clk      (clk),
      .mode     (cell_mode[i]),
      .up_val   (up_val),
      .down_val (down_val),
      .val      (cell_val[i])
    );
  end

  always_comb begin
    out_nxt.error_seen   = res.err_nxt;
    out_nxt.program_done = in_data.end_of_program;
    out_nxt.answer       = '0;
    if (in_data.end_of_program) begin
      if (res.err_nxt || (res.cnt_nxt == '0)) begin
        out_nxt.answer = '1;
      end else begin
        out_nxt.answer = {1'b0, res.new_top};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        cnt_r       <= in_data.end_of_program ? '0 : res.cnt_nxt;
        err_r       <= in_data.end_of_program ? 1'b0 : res.err_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/smev_checker.sv
// Port-level checks for the stack machine evaluator, bound to the top level.
// Depends on smev_pkg and stack_machine_evaluator_core.
`default_nettype none

module smev_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire smev_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire smev_pkg::out_item_t out_data
);

  // every transfer in gives a result in the cycle after it
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after input transfer");

  a_done_matches: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_data.program_done == $past(in_data.end_of_program))
    else $error("program_done does not follow end_of_program");

  a_mid_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.program_done |-> out_data.answer == '0)
    else $error("answer nonzero before end of program");

  a_error_answer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.program_done && out_data.error_seen
      |-> out_data.answer == '1)
    else $error("error program did not answer -1");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

endmodule

bind stack_machine_evaluator_core smev_checker u_smev_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
